FILE: hw/rtl/utf8_strict_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8_strict_filter_unit_macros.svh
// Assertion shorthands shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STRICT_FILTER_UNIT_MACROS_SVH
`define UTF8_STRICT_FILTER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define UTF8SF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define UTF8SF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/utf8sf_pkg.sv
// ----------------------------------------------------------------------------
// utf8sf_pkg
// Types, constants and byte classification for the strict UTF-8 filter.
// ----------------------------------------------------------------------------
package utf8sf_pkg;

    // Lead byte ranges
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;

    // Leads with a narrowed second byte
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_SEC_LO   = 8'hA0;
    localparam logic [7:0] ED_SEC_HI   = 8'h9F;
    localparam logic [7:0] F0_SEC_LO   = 8'h90;
    localparam logic [7:0] F4_SEC_HI   = 8'h8F;

    // Sequence length codes
    localparam logic [2:0] LEN_DROP    = 3'd0;
    localparam logic [2:0] LEN_ASCII   = 3'd1;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    // One queued run: all results caused by one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes in output order, index 0 first
        logic [1:0]      last_idx;  // index of the final result of the run
        logic            marker;    // bare end marker, no byte
        logic            eos;       // run closes the stream
    } run_t;

    // Front to queue
    typedef struct packed {
        logic push;
        run_t run;
    } push_t;

    // Queue to back
    typedef struct packed {
        logic avail;
        run_t run;
    } head_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_DROP;
        if (b == 8'h00)
            len = LEN_DROP;
        else if (b < CONT_TAG)
            len = LEN_ASCII;
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
            len = LEN_TWO;
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
            len = LEN_THREE;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        case (lead)
            LEAD_E0: ok = (b >= E0_SEC_LO) && (b <= CONT_HI);
            LEAD_ED: ok = (b >= CONT_LO) && (b <= ED_SEC_HI);
            LEAD_F0: ok = (b >= F0_SEC_LO) && (b <= CONT_HI);
            LEAD_F4: ok = (b >= CONT_LO) && (b <= F4_SEC_HI);
            default: ok = is_cont(b);
        endcase
        return ok;
    endfunction

endpackage

FILE: hw/rtl/utf8_strict_filter_unit.sv
// ----------------------------------------------------------------------------
// utf8_strict_filter_unit: takes one byte per cycle while the run queue has room.
// A run enters the run queue when its input word is accepted and reaches the
// output after earlier runs; its words leave one per cycle while out_ready is high.
// Reset clears the pending sequence, the run queue and the output position.
// ----------------------------------------------------------------------------
`include "utf8_strict_filter_unit_macros.svh"

module utf8_strict_filter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       last_of_run,
    output logic       end_of_stream
);

    utf8sf_pkg::push_t push;
    utf8sf_pkg::head_t head;
    logic              q_full;
    logic              pop;
    logic              in_fire;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    // Classify words and build runs
    utf8sf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (in_byte),
        .last_in (last_in),
        .push_o  (push)
    );

    // Buffer runs between the two sides
    utf8sf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .full   (q_full),
        .head_o (head)
    );

    // Drain runs to the output
    utf8sf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_i        (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

    // A bare marker closes its run and the stream
    `UTF8SF_ASSERT_SAME(a_marker_shape, out_valid && !has_byte,
        last_of_run && end_of_stream && (out_byte == 8'h00), "malformed end marker")

    // Stream end always falls on a run boundary
    `UTF8SF_ASSERT_SAME(a_eos_closes_run, out_valid && end_of_stream, last_of_run,
        "end of stream inside a run")

    // A final input word always leaves something to deliver
    `UTF8SF_ASSERT_NEXT(a_last_yields_output, in_fire && last_in, out_valid,
        "stream end produced no output")

endmodule

FILE: hw/rtl/utf8sf_front.sv
// ----------------------------------------------------------------------------
// utf8sf_front
// Classifies each input word, holds pending sequence bytes and emits runs.
// ----------------------------------------------------------------------------
module utf8sf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    input  logic              last_in,
    output utf8sf_pkg::push_t push_o
);

    logic [7:0] pend_reg [0:2];
    logic [7:0] pend_next [0:2];
    logic [2:0] seq_len_reg, seq_len_next;
    logic [1:0] held_reg, held_next;

    logic [2:0] len;
    logic       ok;
    logic       emit;
    logic [3:0][7:0] run_bytes;
    logic [1:0] run_last;

    // Classify the word against the pending sequence
    always_comb
    begin
        len       = utf8sf_pkg::lead_len(in_byte);
        ok        = 1'b0;
        emit      = 1'b0;
        run_bytes = {4{in_byte}};
        run_last  = 2'd0;
        seq_len_next = seq_len_reg;
        held_next    = held_reg;
        for (int i = 0; i < 3; i++)
        begin
            pend_next[i] = pend_reg[i];
        end

        if (seq_len_reg != utf8sf_pkg::LEN_DROP)
        begin
            if (held_reg == 2'd1)
                ok = utf8sf_pkg::second_ok(pend_reg[0], in_byte);
            else
                ok = utf8sf_pkg::is_cont(in_byte);
        end

        if (ok && ({1'b0, held_reg} + 3'd1 >= seq_len_reg))
        begin
            // complete: release held bytes followed by this word
            emit     = 1'b1;
            run_last = held_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < held_reg)
                    run_bytes[i] = pend_reg[i];
            end
            seq_len_next = utf8sf_pkg::LEN_DROP;
            held_next    = 2'd0;
        end
        else if (ok)
        begin
            // continue: hold this word
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) == held_reg)
                    pend_next[i] = in_byte;
            end
            held_next = held_reg + 2'd1;
        end
        else
        begin
            // drop anything pending and take the word as a new lead
            seq_len_next = utf8sf_pkg::LEN_DROP;
            held_next    = 2'd0;
            if (len == utf8sf_pkg::LEN_ASCII)
            begin
                emit = 1'b1;
            end
            else if (len != utf8sf_pkg::LEN_DROP)
            begin
                pend_next[0] = in_byte;
                seq_len_next = len;
                held_next    = 2'd1;
            end
        end

        // stream end clears the pending sequence state
        if (last_in)
        begin
            seq_len_next = utf8sf_pkg::LEN_DROP;
            held_next    = 2'd0;
        end

        push_o.push         = in_fire && (emit || last_in);
        push_o.run.bytes    = run_bytes;
        push_o.run.last_idx = emit ? run_last : 2'd0;
        push_o.run.marker   = !emit;
        push_o.run.eos      = last_in;
    end

    // Hold sequence control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= utf8sf_pkg::LEN_DROP;
            held_reg    <= 2'd0;
        end
        else if (in_fire)
        begin
            seq_len_reg <= seq_len_next;
            held_reg    <= held_next;
        end
    end

    // Hold pending bytes
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

endmodule

FILE: hw/rtl/utf8sf_queue.sv
// ----------------------------------------------------------------------------
// utf8sf_queue
// Short run queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module utf8sf_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  utf8sf_pkg::push_t push_i,
    input  logic              pop,
    output logic              full,
    output utf8sf_pkg::head_t head_o
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    utf8sf_pkg::run_t mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full        = (count_reg == FULL_CNT);
    assign do_push     = push_i.push && !full;
    assign do_pop      = pop && (count_reg != '0);
    assign head_o.avail = (count_reg != '0);
    assign head_o.run   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed runs
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_i.run;
    end

endmodule

FILE: hw/rtl/utf8sf_back.sv
// ----------------------------------------------------------------------------
// utf8sf_back
// Serializes the head run into one output word per handshake.
// ----------------------------------------------------------------------------
module utf8sf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  utf8sf_pkg::head_t head_i,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              last_of_run,
    output logic              end_of_stream
);

    logic [1:0] idx_reg, idx_next;
    logic       at_end;
    logic       fire;

    assign out_valid     = head_i.avail;
    assign fire          = out_valid && out_ready;
    assign at_end        = (idx_reg == head_i.run.last_idx);
    assign has_byte      = !head_i.run.marker;
    assign out_byte      = head_i.run.marker ? 8'h00 : head_i.run.bytes[idx_reg];
    assign last_of_run   = at_end;
    assign end_of_stream = at_end && head_i.run.eos;
    assign pop           = fire && at_end;

    // Advance through the run, wrap on its final word
    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

FILE: tb/tb_utf8_strict_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_strict_filter_unit
// Self-checking bench for the strict UTF-8 stream filter. A scoreboard class
// predicts the output words for every accepted input byte and checks each
// accepted output word against them in order. The stimulus is a directed
// sweep of lead, continuation and stream-end cases, a long receiver hold-off,
// and a random mix of well-formed, truncated and malformed sequences and raw
// bytes, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       lor;
    logic       eos;
} utf8_word_t;

class utf8_stream_checker;
    logic [7:0] lead_buf [3];
    int         seq_len;
    int         held;
    utf8_word_t due_words [$];
    int         errors;

    function new();
        seq_len = 0;
        held    = 0;
        errors  = 0;
    endfunction

    function int count();
        return due_words.size();
    endfunction

    // Length of the sequence that b opens: 1 for ASCII, 0 if b is dropped
    function int lead_length(logic [7:0] b);
        if (b == 8'h00)
            return 0;
        if (b < 8'h80)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // Second byte ranges narrowed against overlongs, surrogates and > U+10FFFF
    function bit second_fits(logic [7:0] lead, logic [7:0] b);
        case (lead)
            8'hE0:   return b >= 8'hA0 && b <= 8'hBF;
            8'hED:   return b >= 8'h80 && b <= 8'h9F;
            8'hF0:   return b >= 8'h90 && b <= 8'hBF;
            8'hF4:   return b >= 8'h80 && b <= 8'h8F;
            default: return b[7:6] == 2'b10;
        endcase
    endfunction

    function utf8_word_t data_word(logic [7:0] b);
        utf8_word_t w;
        w.data = b;
        w.has  = 1'b1;
        w.lor  = 1'b0;
        w.eos  = 1'b0;
        return w;
    endfunction

    // Predict the words caused by one accepted input byte
    function void note_word(logic [7:0] b, bit last);
        utf8_word_t run [$];
        utf8_word_t mark;
        int         len;
        bit         fits;
        bit         relead;
        relead = 1'b1;
        if (held != 0) begin
            fits = (held == 1) ? second_fits(lead_buf[0], b) : (b[7:6] == 2'b10);
            if (fits) begin
                relead = 1'b0;
                if (held + 1 >= seq_len) begin
                    for (int i = 0; i < held; i++)
                        run.push_back(data_word(lead_buf[i]));
                    run.push_back(data_word(b));
                    held    = 0;
                    seq_len = 0;
                end
                else begin
                    lead_buf[held] = b;
                    held++;
                end
            end
        end

        // Drop what is held and look at the byte as a new lead
        if (relead) begin
            held    = 0;
            seq_len = 0;
            len     = lead_length(b);
            if (len == 1)
                run.push_back(data_word(b));
            else if (len > 1) begin
                lead_buf[0] = b;
                held        = 1;
                seq_len     = len;
            end
        end

        // Close the stream: drop any cut-off sequence
        if (last) begin
            held    = 0;
            seq_len = 0;
            if (run.size() == 0) begin
                mark.data = 8'h00;
                mark.has  = 1'b0;
                mark.lor  = 1'b1;
                mark.eos  = 1'b1;
                run.push_back(mark);
            end
            else
                run[run.size() - 1].eos = 1'b1;
        end
        if (run.size() > 0)
            run[run.size() - 1].lor = 1'b1;
        foreach (run[i])
            due_words.push_back(run[i]);
    endfunction

    // Compare one accepted output word with the oldest prediction
    function void check_word(logic [7:0] ob, logic hb, logic lr, logic es);
        utf8_word_t w;
        if (due_words.size() == 0) begin
            $error("output word %02h arrived with nothing due", ob);
            errors++;
            return;
        end
        w = due_words.pop_front();
        if (ob !== w.data) begin
            $error("out_byte: expected %02h, actual %02h", w.data, ob);
            errors++;
        end
        if (hb !== w.has) begin
            $error("has_byte: expected %0b, actual %0b", w.has, hb);
            errors++;
        end
        if (lr !== w.lor) begin
            $error("last_of_run: expected %0b, actual %0b", w.lor, lr);
            errors++;
        end
        if (es !== w.eos) begin
            $error("end_of_stream: expected %0b, actual %0b", w.eos, es);
            errors++;
        end
    endfunction
endclass

module tb_utf8_strict_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 29;

    // Directed words: bit 8 is last_in, bits 7:0 the byte
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h001, 9'h07F, 9'h000, 9'h080, 9'h0C1, 9'h0FF,
        9'h0C2, 9'h080,
        9'h0DF, 9'h1BF,
        9'h0E0, 9'h0A0, 9'h080,
        9'h0E0, 9'h09F,
        9'h0ED, 9'h09F, 9'h0BF,
        9'h0F0, 9'h090, 9'h041,
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h0C3, 9'h100,
        9'h0E1
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       last_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       end_of_stream;

    logic       hold_req = 1'b0;
    bit         steady = 1'b0;
    int         burst_left = 0;
    int         cycle_count = 0;
    int         random_sent = 0;

    utf8_stream_checker sb = new();

    utf8_strict_filter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** utf8_strict_filter_unit: FAILED **");
            $finish;
        end
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_byte, has_byte, last_of_run, end_of_stream);
    end

    // Stall the receiver in stretches of varying pattern; honor a long hold-off
    initial
    begin : receiver
        int mode;
        int span;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++) begin
                @(posedge clk);
                if (hold_req) begin
                    hold_req  <= 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= k[1];
                endcase
            end
        end
    end

    // Drop valid and idle; n, at least 1, sets the length of the idle stretch
    task automatic idle(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one word, hold it until accepted, then note it
    task automatic send_word(logic [7:0] b, bit last);
        if (!steady && burst_left == 0) begin
            if ($urandom_range(0, 2) != 0)
                idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        last_in  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(b, last);
    endtask

    // Pause the sender until every predicted word has come out
    task automatic wait_drained();
        idle(1);
        while (sb.count() != 0)
            @(posedge clk);
    endtask

    function automatic bit pick_last();
        return $urandom_range(0, 19) == 0;
    endfunction

    // Build a well-formed sequence of len bytes, byte 0 in bits 7:0
    function automatic logic [31:0] build_seq(int len);
        logic [31:0] s;
        s = '0;
        for (int i = 1; i < 4; i++)
            s[8*i +: 8] = 8'($urandom_range(8'h80, 8'hBF));
        case (len)
            1:       s[7:0] = 8'($urandom_range(8'h01, 8'h7F));
            2:       s[7:0] = 8'($urandom_range(8'hC2, 8'hDF));
            3:       s[7:0] = 8'($urandom_range(8'hE0, 8'hEF));
            default: s[7:0] = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        case (s[7:0])
            8'hE0:   s[15:8] = 8'($urandom_range(8'hA0, 8'hBF));
            8'hED:   s[15:8] = 8'($urandom_range(8'h80, 8'h9F));
            8'hF0:   s[15:8] = 8'($urandom_range(8'h90, 8'hBF));
            8'hF4:   s[15:8] = 8'($urandom_range(8'h80, 8'h8F));
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_bytes(logic [31:0] s, int n);
        for (int i = 0; i < n; i++) begin
            send_word(s[8*i +: 8], pick_last());
            random_sent++;
        end
    endtask

    // One random unit: mostly well-formed, the rest cut off, malformed or raw
    task automatic send_random_unit();
        int          pick;
        int          len;
        logic [31:0] s;
        pick = $urandom_range(0, 99);
        s    = '0;
        if (pick < 70) begin
            len = $urandom_range(1, 4);
            send_bytes(build_seq(len), len);
        end
        else if (pick < 82) begin
            len = $urandom_range(2, 4);
            send_bytes(build_seq(len), $urandom_range(1, len - 1));
        end
        else if (pick < 90) begin
            case ($urandom_range(0, 4))
                0: s[15:0] = {8'($urandom_range(8'h80, 8'h9F)), 8'hE0};
                1: s[15:0] = {8'($urandom_range(8'hA0, 8'hBF)), 8'hED};
                2: s[15:0] = {8'($urandom_range(8'h80, 8'h8F)), 8'hF0};
                3: s[15:0] = {8'($urandom_range(8'h90, 8'hBF)), 8'hF4};
                default: begin
                    s[7:0] = 8'($urandom_range(8'hC2, 8'hF4));
                    if ($urandom_range(0, 1) != 0)
                        s[15:8] = 8'($urandom_range(8'h00, 8'h7F));
                    else
                        s[15:8] = 8'($urandom_range(8'hC0, 8'hFF));
                end
            endcase
            send_bytes(s, 2);
        end
        else begin
            if ($urandom_range(0, 7) == 0)
                s[7:0] = 8'h00;
            else
                s[7:0] = 8'($urandom_range(0, 255));
            send_bytes(s, 1);
        end
    endtask

    initial
    begin : stimulus
        // Hold reset, then release on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sweep of leads, narrowed seconds, breaks and stream ends
        foreach (DIRECTED[i])
            send_word(DIRECTED[i][7:0], DIRECTED[i][8]);
        send_word(8'h80, 1'b1);
        wait_drained();

        // Hold off the receiver while the sender keeps offering words
        hold_req <= 1'b1;
        steady = 1'b1;
        for (int i = 0; i < 24; i++)
            send_word(8'($urandom_range(8'h01, 8'h7F)), 1'b0);
        steady = 1'b0;
        wait_drained();

        // Random mix, with stretches of back-to-back input
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            send_random_unit();
        end
        steady = 1'b0;

        // Drain and let the block settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** utf8_strict_filter_unit: PASSED **");
        else
            $display("** utf8_strict_filter_unit: FAILED **");
        $finish;
    end
endmodule
